// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the EAROM block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/earom_pkg.sv
// ---------------------------------------------------------------------------
// EAROM package
// Transfer types, control pin layout and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package earom_pkg;

  localparam int ADDR_W    = 6;
  localparam int ADDR_SPAN = 64;
  localparam int PIN_W     = 5;

  localparam int PIN_CK  = 0;
  localparam int PIN_C1  = 1;
  localparam int PIN_C2  = 2;
  localparam int PIN_CS1 = 3;
  localparam int PIN_CS2 = 4;

  localparam int CB_CK    = 0;
  localparam int CB_C2    = 1;
  localparam int CB_C1_N  = 2;
  localparam int CB_SEL   = 3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONTROL = 1'b1;

  localparam logic [7:0] ERASED = 8'hFF;

  typedef logic [PIN_W-1:0] pins_t;

  typedef struct packed {
    logic       action;
    logic [7:0] address;
    logic [7:0] data_byte;
    logic [7:0] control_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       modified;
  } rsp_t;

  typedef struct packed {
    pins_t      pins;
    logic       write;
    logic [7:0] wdata;
    logic       set_dirty;
    logic       load_data;
  } upd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// File: hdl/earom_ram.sv
// ---------------------------------------------------------------------------
// EAROM generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module earom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/earom_update.sv
// ---------------------------------------------------------------------------
// EAROM pin update
// Decode a control byte against the held pins and the read cell value.
// ---------------------------------------------------------------------------
`default_nettype none

module earom_update (
  input  wire earom_pkg::pins_t pins_old,
  input  wire logic [7:0]       control_byte,
  input  wire logic [7:0]       stored,
  input  wire logic [7:0]       data_latch,
  output      earom_pkg::upd_t  upd
);

  earom_pkg::pins_t pins_mode;
  logic             sel;
  logic             upd_mode;
  logic             upd_fall;
  logic             mode_and;
  logic             mode_erase;
  logic [7:0]       new_val;

  always_comb begin
    pins_mode                     = '0;
    pins_mode[earom_pkg::PIN_CK]  = pins_old[earom_pkg::PIN_CK];
    pins_mode[earom_pkg::PIN_C1]  = ~control_byte[earom_pkg::CB_C1_N];
    pins_mode[earom_pkg::PIN_C2]  = control_byte[earom_pkg::CB_C2];
    pins_mode[earom_pkg::PIN_CS1] = control_byte[earom_pkg::CB_SEL];
    pins_mode[earom_pkg::PIN_CS2] = 1'b1;

    sel      = pins_mode[earom_pkg::PIN_CS1] & pins_mode[earom_pkg::PIN_CS2];
    upd_mode = sel && (pins_mode != pins_old);
    upd_fall = sel && pins_mode[earom_pkg::PIN_CK] && !control_byte[earom_pkg::CB_CK];

    mode_and   = !pins_mode[earom_pkg::PIN_C1] && !pins_mode[earom_pkg::PIN_C2];
    mode_erase = !pins_mode[earom_pkg::PIN_C1] && pins_mode[earom_pkg::PIN_C2];

    if (mode_and) begin
      new_val = stored & data_latch;
    end else if (mode_erase) begin
      new_val = earom_pkg::ERASED;
    end else begin
      new_val = stored;
    end

    upd.pins                    = pins_mode;
    upd.pins[earom_pkg::PIN_CK] = control_byte[earom_pkg::CB_CK];
    upd.write                   = (upd_mode || upd_fall) && (mode_and || mode_erase);
    upd.wdata                   = new_val;
    upd.set_dirty               = upd.write && (new_val != stored);
    upd.load_data               = upd_fall && pins_mode[earom_pkg::PIN_C1];
  end

endmodule

`default_nettype wire

// File: hdl/earom_64x8_device.sv
// ---------------------------------------------------------------------------
// EAROM 64x8 device
// Byte-wide electrically alterable ROM with address/data latches and pins.
// ---------------------------------------------------------------------------
// Each command has its addressed word read from the cell RAM through its
// registered read port in the accept cycle, then in the execute state the
// word is modified, written back by control transfers and registered as the
// response. While a response is stalled, the next command is still taken but
// holds in the execute state, with cmd_stall high, until the response
// transfers. After reset a clearing pass writes zero to all WORDS cells, one
// per cycle, with cmd_stall held high throughout the pass.
`default_nettype none
`include "assert_macros.svh"

module earom_64x8_device #(
  parameter int WORDS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output      logic            cmd_stall,
  input  wire earom_pkg::cmd_t cmd,
  output      logic            rsp_valid,
  input  wire logic            rsp_stall,
  output      earom_pkg::rsp_t rsp
);

  localparam int IW = $clog2(WORDS);

  earom_pkg::state_t              state;
  earom_pkg::state_t              state_next;
  logic [IW-1:0]                  clr_cnt;
  earom_pkg::cmd_t                item;
  logic [earom_pkg::ADDR_W-1:0]   addr_latch;
  logic [7:0]                     data_latch;
  earom_pkg::pins_t               pins;
  logic                           dirty;

  logic [IW-1:0]                  mod_tbl [earom_pkg::ADDR_SPAN];
  logic [IW-1:0]                  cell_idx;
  logic                           accept;
  logic                           out_free;
  logic                           commit;
  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  logic [7:0]                     ram_wdata;
  logic                           ram_re;
  logic [7:0]                     ram_rdata;
  earom_pkg::upd_t                upd;
  logic                           is_ctrl;

  for (genvar g = 0; g < earom_pkg::ADDR_SPAN; g++) begin : g_mod
    assign mod_tbl[g] = IW'(g % WORDS);
  end

  assign cell_idx = mod_tbl[addr_latch];
  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign is_ctrl  = (item.action == earom_pkg::ACT_CONTROL);

  earom_ram #(
    .WIDTH (8),
    .DEPTH (WORDS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_idx),
    .rdata (ram_rdata)
  );

  earom_update u_update (
    .pins_old     (pins),
    .control_byte (item.control_byte),
    .stored       (ram_rdata),
    .data_latch   (data_latch),
    .upd          (upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      earom_pkg::ST_CLEAR: begin
        if (clr_cnt == IW'(WORDS - 1)) begin
          state_next = earom_pkg::ST_IDLE;
        end
      end
      earom_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = earom_pkg::ST_EXEC;
        end
      end
      earom_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = earom_pkg::ST_IDLE;
        end
      end
      default: state_next = earom_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    commit    = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cell_idx;
    ram_wdata = upd.wdata;
    unique case (state)
      earom_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      earom_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        ram_re    = cmd_valid;
      end
      earom_pkg::ST_EXEC: begin
        commit = out_free;
        ram_we = out_free && is_ctrl && upd.write;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= earom_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      addr_latch <= '0;
      data_latch <= '0;
      pins       <= '0;
      dirty      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == earom_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
        if (is_ctrl) begin
          pins  <= upd.pins;
          dirty <= dirty | upd.set_dirty;
          if (upd.load_data) begin
            data_latch <= ram_rdata;
          end
        end else begin
          addr_latch <= item.address[earom_pkg::ADDR_W-1:0];
          data_latch <= item.data_byte;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
    if (commit) begin
      if (is_ctrl) begin
        rsp.read_data <= upd.load_data ? ram_rdata : data_latch;
        rsp.modified  <= dirty | upd.set_dirty;
      end else begin
        rsp.read_data <= item.data_byte;
        rsp.modified  <= dirty;
      end
    end
  end

  `ASSERT_IMPLY(a_no_rw_overlap, clk, rst, ram_we, !ram_re, "RAM read and write overlap")
  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == earom_pkg::ST_EXEC, "accept without exec")
  `ASSERT_NEXT(a_dirty_sticky, clk, rst, dirty, dirty, "dirty flag dropped")
  `ASSERT_IMPLY(a_read_no_write, clk, rst, commit && is_ctrl && upd.load_data, !ram_we,
                "read latch with cell write")

endmodule

`default_nettype wire

// File: tb/sv/tb_earom_64x8_device.sv
// ---------------------------------------------------------------------------
// EAROM 64x8 device testbench
// Drives load and control-pin transfers into the device: first a short
// directed table that walks erase, AND-write, read, both-mode, unselected
// and out-of-range address cases, then about 1750 random transfers in
// phases with and without sender gaps and receiver stalls, including one
// long receiver hold-off. Responses are checked field by field, typed rows
// against the table, others against shadow cells, latches and control pins.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_earom_64x8_device;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int CELLS        = 64;
  localparam int PHASE_ITEMS  = 350;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    earom_pkg::cmd_t cmd;
    logic            typed;
    logic [7:0]      want_data;
    logic            want_mod;
  } row_t;

  localparam int ROWS = 24;
  localparam row_t PLAN [ROWS] = '{
    '{'{earom_pkg::ACT_LOAD,    8'hFF, 8'hFF, 8'h00}, 1'b1, 8'hFF, 1'b0},
    '{'{earom_pkg::ACT_LOAD,    8'h00, 8'h00, 8'hFF}, 1'b1, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'hFF, 8'hFF, 8'h00}, 1'b1, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'hF0}, 1'b1, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0E}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0F}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0E}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h09}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h08}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_LOAD,    8'h40, 8'h5A, 8'h00}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0D}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0D}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0C}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h09}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h08}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0B}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0A}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_LOAD,    8'hC1, 8'h00, 8'hA5}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0E}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h0C}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h09}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h08}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h07}, 1'b0, 8'h00, 1'b0},
    '{'{earom_pkg::ACT_CONTROL, 8'h00, 8'h00, 8'h06}, 1'b0, 8'h00, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  earom_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  earom_pkg::rsp_t rsp;

  logic [7:0] shadow_cells [CELLS];
  logic [earom_pkg::ADDR_W-1:0] shadow_addr;
  logic [7:0] shadow_data;
  earom_pkg::pins_t shadow_pins;
  logic shadow_dirty;

  earom_pkg::rsp_t pending_rsp [$];
  int mismatches = 0;
  int send_pct = 0;
  int recv_pct = 0;
  bit hold_req = 1'b0;

  earom_64x8_device dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic bit shadow_selected();
    return shadow_pins[earom_pkg::PIN_CS1] && shadow_pins[earom_pkg::PIN_CS2];
  endfunction

  function automatic void shadow_rewrite();
    int unsigned idx;
    logic [7:0] was;
    idx = shadow_addr % CELLS;
    was = shadow_cells[idx];
    if (!shadow_pins[earom_pkg::PIN_C1] && !shadow_pins[earom_pkg::PIN_C2]) begin
      shadow_cells[idx] = was & shadow_data;
    end else if (!shadow_pins[earom_pkg::PIN_C1] && shadow_pins[earom_pkg::PIN_C2]) begin
      shadow_cells[idx] = earom_pkg::ERASED;
    end
    if (shadow_cells[idx] != was) shadow_dirty = 1'b1;
  endfunction

  function automatic earom_pkg::rsp_t shadow_step(earom_pkg::cmd_t c);
    earom_pkg::pins_t was;
    earom_pkg::rsp_t r;
    if (c.action == earom_pkg::ACT_LOAD) begin
      shadow_addr = c.address[earom_pkg::ADDR_W-1:0];
      shadow_data = c.data_byte;
    end else begin
      was = shadow_pins;
      shadow_pins = '0;
      shadow_pins[earom_pkg::PIN_CK]  = was[earom_pkg::PIN_CK];
      shadow_pins[earom_pkg::PIN_CS2] = 1'b1;
      shadow_pins[earom_pkg::PIN_C1]  = !c.control_byte[earom_pkg::CB_C1_N];
      shadow_pins[earom_pkg::PIN_C2]  = c.control_byte[earom_pkg::CB_C2];
      shadow_pins[earom_pkg::PIN_CS1] = c.control_byte[earom_pkg::CB_SEL];
      if (shadow_selected() && shadow_pins != was) shadow_rewrite();
      was = shadow_pins;
      shadow_pins[earom_pkg::PIN_CK] = c.control_byte[earom_pkg::CB_CK];
      if (shadow_selected() && shadow_pins != was && !c.control_byte[earom_pkg::CB_CK]) begin
        if (shadow_pins[earom_pkg::PIN_C1]) shadow_data = shadow_cells[shadow_addr % CELLS];
        shadow_rewrite();
      end
    end
    r.read_data = shadow_data;
    r.modified  = shadow_dirty;
    return r;
  endfunction

  function automatic earom_pkg::cmd_t random_cmd();
    earom_pkg::cmd_t c;
    int k;
    c.address      = 8'($urandom);
    c.data_byte    = 8'($urandom);
    c.control_byte = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 22) begin
      c.action = earom_pkg::ACT_LOAD;
      if ($urandom_range(0, 9) < 6) begin
        c.address[earom_pkg::ADDR_W-1:0] = 6'($urandom_range(0, 7));
      end
    end else begin
      c.action = earom_pkg::ACT_CONTROL;
      if (k < 92) c.control_byte[earom_pkg::CB_SEL] = 1'b1;
    end
    return c;
  endfunction

  // hold valid and payload until the transfer, then record the prediction
  task automatic send_cmd(input earom_pkg::cmd_t c, input bit typed,
                          input earom_pkg::rsp_t want);
    earom_pkg::rsp_t pred;
    while ($urandom_range(0, 99) < send_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pred = shadow_step(c);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    shadow_addr  = '0;
    shadow_data  = '0;
    shadow_pins  = '0;
    shadow_dirty = 1'b0;
  end

  initial begin
    earom_pkg::rsp_t want;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < ROWS; i++) begin
      want.read_data = PLAN[i].want_data;
      want.modified  = PLAN[i].want_mod;
      send_cmd(PLAN[i].cmd, PLAN[i].typed, want);
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 47; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 47; end
        3: begin send_pct = 35; recv_pct = 35; end
        default: begin
          send_pct = 0;
          recv_pct = 20;
          hold_req = 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b0, '0);
    end
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_earom_64x8_device passed");
    end else begin
      $display("tb_earom_64x8_device failed");
    end
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  initial begin
    earom_pkg::rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response, expected none, actual data %02h modified %0b",
                   $time, rsp.read_data, rsp.modified);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.read_data !== want.read_data) begin
            mismatches++;
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want.read_data, rsp.read_data);
          end
          if (rsp.modified !== want.modified) begin
            mismatches++;
            $display("%0t: modified mismatch, expected %0b, actual %0b",
                     $time, want.modified, rsp.modified);
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb_earom_64x8_device failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/earom_pkg.sv
hdl/earom_ram.sv
hdl/earom_update.sv
hdl/earom_64x8_device.sv
tb/sv/tb_earom_64x8_device.sv
